### rtl/core/ppwt_pkg.sv
// Shared types and constants for the pure pursuit waypoint tracker.
// Holds the fixed-point constants, CORDIC angle table and register codes.
// No dependencies.
`timescale 1ns / 1ps

package ppwt_pkg;

  localparam int FRAC_BITS = 16;

  // Item operation codes.
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_POSE   = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_LOOKAHEAD = 1'b0;
  localparam logic CFG_SPEED     = 1'b1;

  // Angles in Q2.30, held in 36-bit signed words.
  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam int CORDIC_STEPS = 30;

  // 1e8 m^2 in Q32 squared-distance units.
  localparam logic [63:0] NEAR_LIMIT = 64'd429496729600000000;

  // round(0.4 * 2^FRAC_BITS)
  localparam logic [31:0] STEER_LIMIT = 32'd26214;

  // Number of quotient bits produced for the steering division.
  localparam int DIV_STEPS = 2 * FRAC_BITS;

  typedef struct packed {
    logic               done;
    logic signed [33:0] sin_v;
    logic signed [33:0] cos_v;
  } cordic_res_t;

  function automatic logic signed [35:0] atan_q30(input logic [4:0] step);
    logic signed [35:0] v;
    unique case (step)
      5'd0:  v = 36'sd843314857;
      5'd1:  v = 36'sd497837829;
      5'd2:  v = 36'sd263043837;
      5'd3:  v = 36'sd133525159;
      5'd4:  v = 36'sd67021687;
      5'd5:  v = 36'sd33543516;
      5'd6:  v = 36'sd16775851;
      5'd7:  v = 36'sd8388437;
      5'd8:  v = 36'sd4194283;
      5'd9:  v = 36'sd2097149;
      5'd10: v = 36'sd1048576;
      5'd11: v = 36'sd524288;
      5'd12: v = 36'sd262144;
      5'd13: v = 36'sd131072;
      5'd14: v = 36'sd65536;
      5'd15: v = 36'sd32768;
      5'd16: v = 36'sd16384;
      5'd17: v = 36'sd8192;
      5'd18: v = 36'sd4096;
      5'd19: v = 36'sd2048;
      5'd20: v = 36'sd1024;
      5'd21: v = 36'sd512;
      5'd22: v = 36'sd256;
      5'd23: v = 36'sd128;
      5'd24: v = 36'sd64;
      5'd25: v = 36'sd32;
      5'd26: v = 36'sd16;
      5'd27: v = 36'sd8;
      5'd28: v = 36'sd4;
      5'd29: v = 36'sd2;
      default: v = 36'sd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/pure_pursuit_waypoint_tracker.sv
// Pure pursuit tracker: a pose item runs two pipelined walks over the single
// waypoint memory read port, 30 CORDIC steps and a 32-step bit-serial divide.
// An append is stored without the block going busy.
// busy is high while a pose is in work; the result strobe lasts one cycle and
// cannot be stalled. Synchronous reset empties the path and loads the default
// lookahead and speed; the waypoint memory itself is not cleared.
`timescale 1ns / 1ps

module pure_pursuit_waypoint_tracker #(
  parameter int MAX_POINTS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_op,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [18:0] in_yaw_angle,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [30:0]        cfg_wdata,
  output logic               out_valid,
  output logic signed [15:0] out_steering,
  output logic [30:0]        out_speed,
  output logic [9:0]         out_target_index,
  output logic [9:0]         out_closest_index
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LSQ, ST_NEAR, ST_LOOK, ST_RD1, ST_RD2, ST_TRIG,
    ST_MUL1, ST_MUL2, ST_ACC, ST_PREP, ST_DIV, ST_FIN
  } state_t;

  state_t state_r;

  logic signed [31:0] mem_x [MAX_POINTS];
  logic signed [31:0] mem_y [MAX_POINTS];
  logic signed [31:0] rd_x_r;
  logic signed [31:0] rd_y_r;

  logic [CW-1:0]      cnt_r;
  logic [AW-1:0]      last_r;
  logic [30:0]        look_r;
  logic [30:0]        drive_r;
  logic [61:0]        lsq_r;
  logic signed [31:0] px_r;
  logic signed [31:0] py_r;
  logic signed [18:0] yaw_r;

  logic [CW-1:0] iss_r;
  logic [AW-1:0] widx_r;
  logic          p1_vld_r;
  logic [AW-1:0] p1_idx_r;
  logic          p2_vld_r;
  logic [AW-1:0] p2_idx_r;
  logic [31:0]   ux_r;
  logic [31:0]   uy_r;
  logic          p3_vld_r;
  logic [AW-1:0] p3_idx_r;
  logic [63:0]   sqx_r;
  logic [63:0]   sqy_r;
  logic [63:0]   best_r;
  logic [AW-1:0] clos_r;
  logic          found_r;
  logic [AW-1:0] tgt_r;

  logic signed [32:0] tdx_r;
  logic signed [32:0] tdy_r;
  logic signed [32:0] c_r;
  logic signed [32:0] s_r;
  logic signed [65:0] prod_r;
  logic signed [65:0] prod2_r;
  logic signed [37:0] ly_r;
  logic [63:0]        r_r;
  logic [31:0]        q_r;
  logic               sat_r;
  logic               zero_r;
  logic               neg_r;
  logic [5:0]         dcnt_r;

  logic               out_valid_r;
  logic signed [15:0] steer_r;
  logic [AW-1:0]      otgt_r;
  logic [AW-1:0]      oclos_r;

  logic                  accept;
  logic                  walking;
  logic                  issuing;
  logic                  drained;
  logic [AW-1:0]         widx_nxt;
  logic signed [32:0]    dx;
  logic signed [32:0]    dy;
  logic [64:0]           d2;
  logic signed [66:0]    acc;
  logic signed [66:0]    acc_rnd;
  logic [37:0]           ly_abs;
  logic [63:0]           r0;
  logic [63:0]           r_sh;
  logic [31:0]           mag;
  logic                  cordic_start;
  ppwt_pkg::cordic_res_t cres;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign walking = (state_r == ST_NEAR) || (state_r == ST_LOOK);
  assign issuing = walking && (iss_r != cnt_r);
  assign drained = (iss_r == cnt_r) && !p1_vld_r && !p2_vld_r && !p3_vld_r;
  assign widx_nxt = ((CW'(widx_r) + 1'b1) == cnt_r) ? '0 : widx_r + 1'b1;

  assign dx = 33'(rd_x_r) - 33'(px_r);
  assign dy = 33'(rd_y_r) - 33'(py_r);
  assign d2 = {1'b0, sqx_r} + {1'b0, sqy_r};

  assign acc     = 67'(prod_r) - 67'(prod2_r);
  assign acc_rnd = acc + 67'sd268435456;
  assign ly_abs  = ly_r[37] ? 38'(-ly_r) : 38'(ly_r);
  assign r0      = {25'b0, ly_abs, 1'b0};
  assign r_sh    = {r_r[62:0], 1'b0};
  assign mag     = zero_r ? '0 :
                   (sat_r || (q_r > ppwt_pkg::STEER_LIMIT)) ? ppwt_pkg::STEER_LIMIT : q_r;

  assign cordic_start = (state_r == ST_RD2);

  ppwt_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .yaw   (yaw_r),
    .res   (cres)
  );

  // Waypoint memory: one write port for appends, one registered read port.
  always_ff @(posedge clk) begin
    if (accept && (in_op == ppwt_pkg::OP_APPEND) && (cnt_r != CW'(MAX_POINTS))) begin
      mem_x[cnt_r[AW-1:0]] <= in_pos_x;
      mem_y[cnt_r[AW-1:0]] <= in_pos_y;
    end
    rd_x_r <= mem_x[widx_r];
    rd_y_r <= mem_y[widx_r];
  end

  // Distance pipeline shared by both walks.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= issuing;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
    end
    p1_idx_r <= widx_r;
    p2_idx_r <= p1_idx_r;
    p3_idx_r <= p2_idx_r;
    ux_r     <= dx[32] ? 32'(-dx) : 32'(dx);
    uy_r     <= dy[32] ? 32'(-dy) : 32'(dy);
    sqx_r    <= ux_r * ux_r;
    sqy_r    <= uy_r * uy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      last_r      <= '0;
      look_r      <= 31'd65536;
      drive_r     <= 31'd98304;
      out_valid_r <= 1'b0;
      iss_r       <= '0;
      widx_r      <= '0;
      found_r     <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          ppwt_pkg::CFG_LOOKAHEAD: look_r  <= cfg_wdata;
          ppwt_pkg::CFG_SPEED:     drive_r <= cfg_wdata;
          default:                 ;
        endcase
      end
      if (issuing) begin
        iss_r  <= iss_r + 1'b1;
        widx_r <= widx_nxt;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_op == ppwt_pkg::OP_APPEND) begin
              if (cnt_r != CW'(MAX_POINTS)) begin
                cnt_r <= cnt_r + 1'b1;
              end
            end else if (cnt_r != '0) begin
              px_r    <= in_pos_x;
              py_r    <= in_pos_y;
              yaw_r   <= in_yaw_angle;
              state_r <= ST_LSQ;
            end
          end
        end
        ST_LSQ: begin
          lsq_r   <= look_r * look_r;
          iss_r   <= '0;
          widx_r  <= last_r;
          best_r  <= ppwt_pkg::NEAR_LIMIT;
          clos_r  <= last_r;
          state_r <= ST_NEAR;
        end
        ST_NEAR: begin
          if (p3_vld_r && (d2 < {1'b0, best_r})) begin
            best_r <= d2[63:0];
            clos_r <= p3_idx_r;
          end
          if (drained) begin
            last_r  <= clos_r;
            widx_r  <= clos_r;
            iss_r   <= '0;
            found_r <= 1'b0;
            state_r <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          // The first point at or beyond the lookahead radius wins.
          if (p3_vld_r && !found_r && (d2 >= {3'b0, lsq_r})) begin
            found_r <= 1'b1;
            tgt_r   <= p3_idx_r;
          end
          if (drained) begin
            if (!found_r) begin
              tgt_r <= clos_r;
            end
            widx_r  <= found_r ? tgt_r : clos_r;
            state_r <= ST_RD1;
          end
        end
        ST_RD1: begin
          state_r <= ST_RD2;
        end
        ST_RD2: begin
          tdx_r   <= dx;
          tdy_r   <= dy;
          state_r <= ST_TRIG;
        end
        ST_TRIG: begin
          if (cres.done) begin
            c_r     <= 33'(cres.cos_v >>> 1);
            s_r     <= 33'(cres.sin_v >>> 1);
            state_r <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          prod_r  <= c_r * tdy_r;
          state_r <= ST_MUL2;
        end
        ST_MUL2: begin
          prod2_r <= s_r * tdx_r;
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          ly_r    <= 38'(acc_rnd >>> 29);
          state_r <= ST_PREP;
        end
        ST_PREP: begin
          r_r     <= r0;
          q_r     <= '0;
          neg_r   <= ly_r[37];
          zero_r  <= (ly_r == '0);
          sat_r   <= (r0 >= {2'b0, lsq_r});
          dcnt_r  <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          // Restoring division, one quotient bit a cycle.
          if (r_sh >= {2'b0, lsq_r}) begin
            r_r <= r_sh - {2'b0, lsq_r};
            q_r <= {q_r[30:0], 1'b1};
          end else begin
            r_r <= r_sh;
            q_r <= {q_r[30:0], 1'b0};
          end
          if (dcnt_r == 6'(ppwt_pkg::DIV_STEPS - 1)) begin
            state_r <= ST_FIN;
          end
          dcnt_r <= dcnt_r + 6'd1;
        end
        ST_FIN: begin
          steer_r     <= neg_r ? -16'(mag) : 16'(mag);
          otgt_r      <= tgt_r;
          oclos_r     <= clos_r;
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_steering      = steer_r;
  assign out_speed         = drive_r;
  assign out_target_index  = 10'(otgt_r);
  assign out_closest_index = 10'(oclos_r);

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_POINTS)) else $error("point count beyond capacity");

  a_last_in_path: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> (CW'(last_r) < cnt_r)) else $error("last closest outside path");

  a_empty_pose: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_op == ppwt_pkg::OP_POSE) && (cnt_r == '0)) |=> !busy)
    else $error("pose on empty path started work");

  a_walk_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD1) |-> (!p1_vld_r && !p2_vld_r && !p3_vld_r))
    else $error("distance pipeline not drained");

endmodule

### rtl/core/ppwt_cordic.sv
// Iterative CORDIC giving sine and cosine of the car heading in Q2.30.
// One rotation step per cycle through a shared shift/add unit.
// Depends on ppwt_pkg.
`timescale 1ns / 1ps

module ppwt_cordic (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [18:0]    yaw,
  output ppwt_pkg::cordic_res_t res
);

  logic               busy_r;
  logic               done_r;
  logic [4:0]         step_r;
  logic signed [33:0] x_r;
  logic signed [33:0] y_r;
  logic signed [35:0] z_r;
  logic               neg_r;

  logic signed [35:0] z0;
  logic signed [35:0] z1;
  logic signed [35:0] z2;
  logic               neg0;
  logic signed [33:0] sx;
  logic signed [33:0] sy;
  logic signed [35:0] at;

  // Heading to Q2.30, folded into [-pi, pi] and then into [-pi/2, pi/2].
  always_comb begin
    z0 = {{3{yaw[18]}}, yaw, 14'b0};
    if (z0 > ppwt_pkg::PI_Q30) begin
      z1 = z0 - ppwt_pkg::TWO_PI_Q30;
    end else if (z0 < -ppwt_pkg::PI_Q30) begin
      z1 = z0 + ppwt_pkg::TWO_PI_Q30;
    end else begin
      z1 = z0;
    end
    neg0 = 1'b0;
    z2   = z1;
    if (z1 > ppwt_pkg::HALF_PI_Q30) begin
      z2   = z1 - ppwt_pkg::PI_Q30;
      neg0 = 1'b1;
    end else if (z1 < -ppwt_pkg::HALF_PI_Q30) begin
      z2   = z1 + ppwt_pkg::PI_Q30;
      neg0 = 1'b1;
    end
  end

  assign sx = y_r >>> step_r;
  assign sy = x_r >>> step_r;
  assign at = ppwt_pkg::atan_q30(step_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        x_r    <= ppwt_pkg::CORDIC_GAIN;
        y_r    <= '0;
        z_r    <= z2;
        neg_r  <= neg0;
      end else if (busy_r) begin
        if (!z_r[35]) begin
          x_r <= x_r - sx;
          y_r <= y_r + sy;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + sx;
          y_r <= y_r - sy;
          z_r <= z_r + at;
        end
        if (step_r == 5'(ppwt_pkg::CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 5'd1;
        end
      end
    end
  end

  assign res.done  = done_r;
  assign res.cos_v = neg_r ? -x_r : x_r;
  assign res.sin_v = neg_r ? -y_r : y_r;

endmodule
